// ===== hw/rtl/rgb_to_hsl_converter_core_assert.svh =====
// Assertion macros shared by the RGB to HSL converter RTL
`ifndef RGB_TO_HSL_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> cons) \
        else $error("assertion failed");
`define ASSERT_HOLDS(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define ASSERT_HOLDS(label, clock, resetn, cond)
`endif
`endif

// ===== hw/rtl/rgbhsl_pkg.sv =====
// Package: types, constants and codes of the RGB to HSL converter
`timescale 1ns / 1ps
package rgbhsl_pkg;

    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 15;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 24;
    localparam int DEN_W      = 8;
    localparam int DIV_STAGES = 6;
    localparam int DIV_STEP   = 3;
    localparam int QUO_W      = DIV_STAGES * DIV_STEP;
    localparam int HUE_Q_W    = 12;

    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 1;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [HUE_W-1:0] HUE_SIXTH    = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_GREEN_AT = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_AT  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL     = 15'd23040;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red_level;
        logic [CHAN_W-1:0] green_level;
        logic [CHAN_W-1:0] blue_level;
    } rgb_pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_angle;
        logic [FRAC_W-1:0] saturation_frac;
        logic [FRAC_W-1:0] lightness_frac;
    } hsl_pixel_t;

    typedef struct packed {
        logic              grey;
        logic [1:0]        sector;
        logic              neg;
        logic [FRAC_W-1:0] light;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        side_t            side;
    } div_req_t;

    typedef struct packed {
        logic [QUO_W-1:0] sat_quo;
        logic [QUO_W-1:0] hue_quo;
        side_t            side;
    } div_res_t;

endpackage

// ===== hw/rtl/rgbhsl_front.sv =====
// Front end: channel extremes, sector, lightness and divider operands
`timescale 1ns / 1ps
module rgbhsl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rgbhsl_pkg::rgb_pixel_t pixel,
    output logic                  out_valid,
    output rgbhsl_pkg::div_req_t  out_req
);
    import rgbhsl_pkg::*;

    logic              s1_valid_reg;
    rgb_pixel_t        s1_pix_reg;
    logic [CHAN_W-1:0] s1_hi_reg;
    logic [CHAN_W-1:0] s1_lo_reg;
    logic [1:0]        s1_sector_reg;

    logic [CHAN_W-1:0] hi_next;
    logic [CHAN_W-1:0] lo_next;
    logic [1:0]        sector_next;

    logic              s2_valid_reg;
    div_req_t          s2_req_reg;
    div_req_t          req_next;

    logic [CHAN_W:0]   sum;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] denom;
    logic [CHAN_W:0]   diff;
    logic [CHAN_W:0]   diff_abs;
    logic [CHAN_W-1:0] mag;
    logic [16:0]       light_full;

    always_comb
    begin
        if (pixel.red_level > pixel.green_level)
        begin
            hi_next     = pixel.red_level;
            lo_next     = pixel.green_level;
            sector_next = SECTOR_RED;
        end
        else
        begin
            hi_next     = pixel.green_level;
            lo_next     = pixel.red_level;
            sector_next = SECTOR_GREEN;
        end
        if (hi_next < pixel.blue_level)
        begin
            hi_next     = pixel.blue_level;
            sector_next = SECTOR_BLUE;
        end
        if (lo_next > pixel.blue_level)
        begin
            lo_next = pixel.blue_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg    <= pixel;
        s1_hi_reg     <= hi_next;
        s1_lo_reg     <= lo_next;
        s1_sector_reg <= sector_next;
    end

    always_comb
    begin
        sum   = {1'b0, s1_hi_reg} + {1'b0, s1_lo_reg};
        delta = s1_hi_reg - s1_lo_reg;
        if (sum > 9'd255)
        begin
            denom = CHAN_W'(9'd510 - sum);
        end
        else
        begin
            denom = sum[CHAN_W-1:0];
        end

        case (s1_sector_reg)
            SECTOR_RED:
            begin
                diff = {1'b0, s1_pix_reg.green_level} - {1'b0, s1_pix_reg.blue_level};
            end
            SECTOR_GREEN:
            begin
                diff = {1'b0, s1_pix_reg.blue_level} - {1'b0, s1_pix_reg.red_level};
            end
            SECTOR_BLUE:
            begin
                diff = {1'b0, s1_pix_reg.red_level} - {1'b0, s1_pix_reg.green_level};
            end
            default:
            begin
                diff = '0;
            end
        endcase
        diff_abs   = diff[CHAN_W] ? (~diff + 9'd1) : diff;
        mag        = diff_abs[CHAN_W-1:0];
        light_full = {sum, 8'b0} + {8'b0, sum};

        req_next.sat_num     = {delta, 16'b0};
        req_next.sat_den     = denom;
        req_next.hue_num     = NUM_W'({mag, 12'b0}) - NUM_W'({mag, 8'b0});
        req_next.hue_den     = delta;
        req_next.side.grey   = (delta == '0);
        req_next.side.sector = s1_sector_reg;
        req_next.side.neg    = diff[CHAN_W];
        req_next.side.light  = light_full[16:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_req_reg <= req_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_req   = s2_req_reg;

endmodule

// ===== hw/rtl/rgbhsl_div.sv =====
// Pipelined restoring divider: saturation and hue quotients side by side
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_core_assert.svh"
module rgbhsl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rgbhsl_pkg::div_req_t in_req,
    output logic                 out_valid,
    output rgbhsl_pkg::div_res_t out_res
);
    import rgbhsl_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] rest;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } lane_t;

    typedef struct packed {
        lane_t sat;
        lane_t hue;
        side_t side;
    } stage_t;

    function automatic lane_t lane_load(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
        lane_t l;
        l.rem  = DEN_W'(num[NUM_W-1:QUO_W]);
        l.rest = num[QUO_W-1:0];
        l.quo  = '0;
        l.den  = den;
        return l;
    endfunction

    function automatic lane_t lane_adv(lane_t l);
        lane_t        r;
        logic [DEN_W:0] t;
        r = l;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            t      = {r.rem, r.rest[QUO_W-1]};
            r.rest = {r.rest[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, r.den})
            begin
                r.rem = DEN_W'(t - {1'b0, r.den});
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = t[DEN_W-1:0];
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic   stage_valid_reg [DIV_STAGES];
    stage_t stage_reg       [DIV_STAGES];
    stage_t stage_in        [DIV_STAGES];
    stage_t stage_next      [DIV_STAGES];

    always_comb
    begin
        stage_in[0].sat  = lane_load(in_req.sat_num, in_req.sat_den);
        stage_in[0].hue  = lane_load(in_req.hue_num, in_req.hue_den);
        stage_in[0].side = in_req.side;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stage_in[s] = stage_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stage_next[s].sat  = lane_adv(stage_in[s].sat);
            stage_next[s].hue  = lane_adv(stage_in[s].hue);
            stage_next[s].side = stage_in[s].side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                stage_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            stage_valid_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                stage_valid_reg[s] <= stage_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    assign out_valid       = stage_valid_reg[DIV_STAGES-1];
    assign out_res.sat_quo = stage_reg[DIV_STAGES-1].sat.quo;
    assign out_res.hue_quo = stage_reg[DIV_STAGES-1].hue.quo;
    assign out_res.side    = stage_reg[DIV_STAGES-1].side;

    `ASSERT_IMPLY(a_sat_rem_below_den, clk, rst_n,
        out_valid && !out_res.side.grey,
        stage_reg[DIV_STAGES-1].sat.rem < stage_reg[DIV_STAGES-1].sat.den)
    `ASSERT_IMPLY(a_hue_rem_below_den, clk, rst_n,
        out_valid && !out_res.side.grey,
        stage_reg[DIV_STAGES-1].hue.rem < stage_reg[DIV_STAGES-1].hue.den)
    `ASSERT_IMPLY(a_hue_quo_in_sixth, clk, rst_n,
        out_valid && !out_res.side.grey,
        out_res.hue_quo <= QUO_W'(HUE_SIXTH))

endmodule

// ===== hw/rtl/rgbhsl_back.sv =====
// Back end: sector offset, saturation clamp and result register
`timescale 1ns / 1ps
module rgbhsl_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  rgbhsl_pkg::div_res_t   in_res,
    output logic                   result_valid,
    output rgbhsl_pkg::hsl_pixel_t result
);
    import rgbhsl_pkg::*;

    logic               valid_reg;
    hsl_pixel_t         result_reg;
    hsl_pixel_t         result_next;
    logic [HUE_W-1:0]   q;

    always_comb
    begin
        q = HUE_W'(in_res.hue_quo[HUE_Q_W-1:0]);
        result_next.lightness_frac = in_res.side.light;

        if (in_res.sat_quo[QUO_W-1:FRAC_W] != '0)
        begin
            result_next.saturation_frac = '1;
        end
        else
        begin
            result_next.saturation_frac = in_res.sat_quo[FRAC_W-1:0];
        end

        case (in_res.side.sector)
            SECTOR_RED:
            begin
                if (in_res.side.neg && (q != '0))
                begin
                    result_next.hue_angle = HUE_FULL - q;
                end
                else
                begin
                    result_next.hue_angle = q;
                end
            end
            SECTOR_GREEN:
            begin
                result_next.hue_angle = in_res.side.neg ? (HUE_GREEN_AT - q)
                                                        : (HUE_GREEN_AT + q);
            end
            SECTOR_BLUE:
            begin
                result_next.hue_angle = in_res.side.neg ? (HUE_BLUE_AT - q)
                                                        : (HUE_BLUE_AT + q);
            end
            default:
            begin
                result_next.hue_angle = '0;
            end
        endcase

        if (in_res.side.grey)
        begin
            result_next.hue_angle       = '0;
            result_next.saturation_frac = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/rgb_to_hsl_converter_core.sv =====
// Top level of the RGB to HSL converter
//
//   channel   direction  handshake                 payload
//   pixel     in         start (busy always low)    rgb_pixel_t
//   result    out        result_valid strobe        hsl_pixel_t
//
// One transaction per clock, as busy is held low: 2 front-end stages, 6 divider
// stages of 3 quotient bits each, 1 output register. The pipeline never
// stalls, so a new pixel can enter while earlier ones are still in flight.
// Reset clears every valid bit; transactions in flight are dropped.
// The receiver cannot stall: each result strobes for exactly one cycle.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_core_assert.svh"
module rgb_to_hsl_converter_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rgbhsl_pkg::rgb_pixel_t pixel,
    output logic                   result_valid,
    output rgbhsl_pkg::hsl_pixel_t result
);
    import rgbhsl_pkg::*;

    logic     front_valid;
    div_req_t front_req;
    logic     div_valid;
    div_res_t div_res;
    logic     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rgbhsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (front_valid),
        .out_req   (front_req)
    );

    rgbhsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_req    (front_req),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    rgbhsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_res       (div_res),
        .result_valid (result_valid),
        .result       (result)
    );

    `ASSERT_IMPLY(a_result_follows_start, clk, rst_n, accept, ##PIPE_LATENCY result_valid)
    `ASSERT_IMPLY(a_no_spurious_result, clk, rst_n, result_valid,
        $past(accept, PIPE_LATENCY))
    `ASSERT_IMPLY(a_hue_in_range, clk, rst_n, result_valid, result.hue_angle < HUE_FULL)
    `ASSERT_IMPLY(a_grey_has_no_hue, clk, rst_n,
        result_valid && (result.saturation_frac == '0), result.hue_angle == '0)

endmodule

// ===== sim/rgb_to_hsl_converter_core_tb.sv =====
// Self-checking testbench for the RGB to HSL converter: directed and random pixels
`timescale 1ns / 1ps
module rgb_to_hsl_converter_core_tb;
    import rgbhsl_pkg::*;

    localparam int RANDOM_PIXELS  = 1500;
    localparam int WATCHDOG_LIMIT = 1000;

    class hsl_scoreboard;
        hsl_pixel_t expected_hsl_q[$];
        int         mismatches;
        int         checked;
        int         pixels_in;
        int         greys;
        int         sector_hits[3];

        function hsl_pixel_t predict_hsl(rgb_pixel_t px);
            int         r, g, b;
            int         top, bottom, total, spread, denom;
            int         hue, sat, light;
            logic [1:0] sector;
            hsl_pixel_t hsl;
            r = int'(px.red_level);
            g = int'(px.green_level);
            b = int'(px.blue_level);
            if (r > g)
            begin
                top = r;
                bottom = g;
                sector = SECTOR_RED;
            end
            else
            begin
                top = g;
                bottom = r;
                sector = SECTOR_GREEN;
            end
            if (b > top)
            begin
                top = b;
                sector = SECTOR_BLUE;
            end
            if (b < bottom)
                bottom = b;
            total  = top + bottom;
            spread = top - bottom;
            light  = (total * 65535) / 510;
            if (spread == 0)
            begin
                hue = 0;
                sat = 0;
                greys++;
            end
            else
            begin
                denom = 255 - ((total > 255) ? total - 255 : 255 - total);
                if (denom < 1)
                    denom = 1;
                sat = (spread * 65536) / denom;
                if (sat > 65535)
                    sat = 65535;
                case (sector)
                    SECTOR_RED:
                    begin
                        hue = (int'(HUE_SIXTH) * (g - b)) / spread;
                        if (hue < 0)
                            hue += int'(HUE_FULL);
                    end
                    SECTOR_GREEN:
                        hue = (int'(HUE_SIXTH) * (b - r)) / spread + int'(HUE_GREEN_AT);
                    default:
                        hue = (int'(HUE_SIXTH) * (r - g)) / spread + int'(HUE_BLUE_AT);
                endcase
                sector_hits[sector]++;
            end
            hsl.hue_angle       = hue[HUE_W-1:0];
            hsl.saturation_frac = sat[FRAC_W-1:0];
            hsl.lightness_frac  = light[FRAC_W-1:0];
            return hsl;
        endfunction

        function void note_pixel(rgb_pixel_t px);
            pixels_in++;
            expected_hsl_q.push_back(predict_hsl(px));
        endfunction

        function int pending();
            return expected_hsl_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(hsl_pixel_t got);
            hsl_pixel_t want;
            if (expected_hsl_q.size() == 0)
            begin
                report($sformatf("unexpected result h=%0d s=%0d l=%0d",
                                 got.hue_angle, got.saturation_frac, got.lightness_frac));
                return;
            end
            want = expected_hsl_q.pop_front();
            checked++;
            if (got.hue_angle !== want.hue_angle)
                report($sformatf("hue_angle got %0d want %0d", got.hue_angle, want.hue_angle));
            if (got.saturation_frac !== want.saturation_frac)
                report($sformatf("saturation_frac got %0d want %0d",
                                 got.saturation_frac, want.saturation_frac));
            if (got.lightness_frac !== want.lightness_frac)
                report($sformatf("lightness_frac got %0d want %0d",
                                 got.lightness_frac, want.lightness_frac));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    rgb_pixel_t pixel;
    logic       result_valid;
    hsl_pixel_t result;

    hsl_scoreboard sb;
    bit            idle_en;
    int            quiet_cycles;

    rgb_to_hsl_converter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pixel(pixel);
            if (result_valid)
                sb.check_result(result);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", sb.pending());
                $display("** rgb_to_hsl_converter_core: FAILED **");
                $finish;
            end
        end
    end

    task send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (idle_en && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start              <= 1'b1;
        pixel.red_level    <= r;
        pixel.green_level  <= g;
        pixel.blue_level   <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task drain_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task send_random_pixel();
        logic [7:0] r, g, b, v;
        case ($urandom_range(9))
            0:
            begin
                v = 8'($urandom);
                r = v;
                g = v;
                b = v;
            end
            1:
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
                case ($urandom_range(2))
                    0: g = r;
                    1: b = r;
                    default: b = g;
                endcase
            end
            2:
            begin
                r = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : 8'($urandom));
                g = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : 8'($urandom));
                b = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : 8'($urandom));
            end
            default:
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
        endcase
        send_pixel(r, g, b);
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel        = '0;
        idle_en      = 1'b1;
        quiet_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // greys, black and white
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        // primaries and secondaries, full saturation clamp
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        // red sector wrapping negative
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd200, 8'd10, 8'd11);
        // ties: red equal green, blue equal maximum, blue equal minimum
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50, 8'd200, 8'd200);
        send_pixel(8'd200, 8'd50, 8'd200);
        send_pixel(8'd50, 8'd50, 8'd200);
        send_pixel(8'd200, 8'd100, 8'd100);
        // tiny spreads, bright and dark halves
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd127, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd200, 8'd100);
        send_pixel(8'd30, 8'd60, 8'd90);
        send_pixel(8'd90, 8'd60, 8'd30);
        send_pixel(8'd60, 8'd30, 8'd90);
        send_pixel(8'd170, 8'd85, 8'd0);
        drain_results();

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            idle_en = !(i >= 600 && i < 900);
            if (i == 1100)
                drain_results();
            send_random_pixel();
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);

        $display("Converted %0d pixels, checked %0d results, %0d mismatches",
                 sb.pixels_in, sb.checked, sb.mismatches);
        $display("Greys %0d; red/green/blue dominant %0d/%0d/%0d",
                 sb.greys, sb.sector_hits[SECTOR_RED], sb.sector_hits[SECTOR_GREEN],
                 sb.sector_hits[SECTOR_BLUE]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** rgb_to_hsl_converter_core: PASSED **");
        else
            $display("** rgb_to_hsl_converter_core: FAILED **");
        $finish;
    end

endmodule
